// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the ready queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is held.
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, inactive while reset is held.
`define AST_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check across reset failed");

`endif

// ===== rtl/trq_pkg.sv =====
// Types and codes shared by the ready queue modules.
package trq_pkg;

    localparam logic [2:0] FN_ENQ   = 3'd0;
    localparam logic [2:0] FN_DEQ   = 3'd1;
    localparam logic [2:0] FN_DEL   = 3'd2;
    localparam logic [2:0] FN_FIND  = 3'd3;
    localparam logic [2:0] FN_SEL   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] thread_id;
        logic [7:0] priority_req;
        logic [7:0] waits_for;
        logic [7:0] awaited_id;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] found_id;
        logic [7:0] found_priority;
        logic [1:0] status;
        logic [5:0] occupancy;
    } t_out_beat;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_DEL,
        OP_FIND,
        OP_SEL,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] thread_id;
        logic [7:0] priority_req;
        logic [7:0] waits_for;
        logic [7:0] awaited_id;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

endpackage

// ===== rtl/trq_front.sv =====
// Front end: accepts input beats, decodes them and buffers them in a short queue.
module trq_front import trq_pkg::*; #(
    parameter int ID_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_data,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int         MB    = (ID_BITS < 8) ? ID_BITS : 8;
    localparam logic [8:0] MASK9 = (9'd1 << MB) - 9'd1;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    // Decode the function code and keep ids in their low bits
    always_comb begin
        w_cmd.thread_id    = i_in_data.thread_id & MASK9[7:0];
        w_cmd.priority_req = i_in_data.priority_req;
        w_cmd.waits_for    = i_in_data.waits_for & MASK9[7:0];
        w_cmd.awaited_id   = i_in_data.awaited_id & MASK9[7:0];
        case (i_in_data.func)
            FN_ENQ:  w_cmd.op = OP_ENQ;
            FN_DEQ:  w_cmd.op = OP_DEQ;
            FN_DEL:  w_cmd.op = OP_DEL;
            FN_FIND: w_cmd.op = OP_FIND;
            FN_SEL:  w_cmd.op = OP_SEL;
            default: w_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Advance the queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Hold the buffered commands
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

endmodule

// ===== rtl/trq_back.sv =====
// Back end: entry store, scan and compaction sequencer, and the result register.
module trq_back import trq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_out_valid,
    output t_out_beat  o_out_data,
    input  logic       i_out_stall
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = (ID_BITS > 8) ? ID_BITS : 8;
    localparam int OW = (CW > 6) ? CW : 6;
    localparam int MW = 2 * ID_BITS + 8;

    logic [MW-1:0]      mem [QUEUE_DEPTH];

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_addr, n_addr;
    logic               r_rd_vld, n_rd_vld;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic [MW-1:0]      r_rd_data;
    logic               r_hit, n_hit;
    logic [CW-1:0]      r_pos, n_pos;
    logic [ID_BITS-1:0] r_best_id, n_best_id;
    logic [7:0]         r_best_prio, n_best_prio;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_out_vld, n_out_vld;
    t_out_beat          r_out, n_out;
    logic [7:0]         r_ceiling;

    logic               w_issue;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [MW-1:0]      w_wdata;
    logic [CW-1:0]      w_dec;
    logic               w_match;

    logic [XW-1:0]      x_tid, x_waits, x_awaited, x_best;
    logic [OW-1:0]      x_occ;
    logic [ID_BITS-1:0] c_tid, c_waits, c_awaited;
    logic [ID_BITS-1:0] d_id, d_wait;
    logic [7:0]         d_prio;

    // Widen or trim ids to the stored width
    assign x_tid     = XW'(r_cmd.thread_id);
    assign x_waits   = XW'(r_cmd.waits_for);
    assign x_awaited = XW'(r_cmd.awaited_id);
    assign c_tid     = x_tid[ID_BITS-1:0];
    assign c_waits   = x_waits[ID_BITS-1:0];
    assign c_awaited = x_awaited[ID_BITS-1:0];
    assign x_best    = XW'(r_best_id);
    assign x_occ     = OW'(r_count);

    assign d_id   = r_rd_data[MW-1 -: ID_BITS];
    assign d_prio = r_rd_data[ID_BITS +: 8];
    assign d_wait = r_rd_data[ID_BITS-1:0];
    assign w_dec  = r_rd_idx - CW'(1);

    // Match rule of the current scan
    always_comb begin
        case (r_cmd.op)
            OP_DEQ:  w_match = !r_hit;
            OP_DEL:  w_match = !r_hit && (d_id == c_tid);
            OP_FIND: w_match = !r_hit && (d_wait == c_awaited);
            OP_SEL:  w_match = (d_prio <= r_ceiling) && (!r_hit || d_prio < r_best_prio);
            default: w_match = 1'b0;
        endcase
    end

    // Sequencer: next state, memory port control and result
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_addr       = r_addr;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_best_id    = r_best_id;
        n_best_prio  = r_best_prio;
        n_res_status = r_res_status;
        n_out        = r_out;
        n_out_vld    = r_out_vld && i_out_stall;
        o_cmd_pop    = 1'b0;
        w_issue      = 1'b0;
        w_raddr      = r_addr[AW-1:0];
        w_we         = 1'b0;
        w_waddr      = w_dec[AW-1:0];
        w_wdata      = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_hit        = 1'b0;
                n_pos        = '0;
                n_addr       = '0;
                n_best_id    = '0;
                n_best_prio  = '0;
                n_res_status = ST_EMPTY;
                n_state      = S_RESP;
                case (r_cmd.op)
                    OP_ENQ: begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            w_waddr      = r_count[AW-1:0];
                            w_wdata      = {c_tid, r_cmd.priority_req, c_waits};
                            n_count      = r_count + CW'(1);
                            n_res_status = ST_OK;
                        end
                    end
                    OP_DEQ, OP_DEL, OP_FIND, OP_SEL: begin
                        if (r_count != '0) n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_addr < r_count) begin
                    w_issue = 1'b1;
                    n_addr  = r_addr + CW'(1);
                end
                if (r_rd_vld && w_match) begin
                    n_hit       = 1'b1;
                    n_pos       = r_rd_idx;
                    n_best_id   = d_id;
                    n_best_prio = d_prio;
                end
                if (r_addr >= r_count && !r_rd_vld) begin
                    n_state = S_RESP;
                    if (r_hit) begin
                        n_res_status = ST_OK;
                        if (r_cmd.op == OP_DEQ || r_cmd.op == OP_DEL) begin
                            n_addr  = r_pos + CW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_addr < r_count) begin
                    w_issue = 1'b1;
                    n_addr  = r_addr + CW'(1);
                end
                if (r_rd_vld) w_we = 1'b1;
                if (r_addr >= r_count && !r_rd_vld) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.found_id       = x_best[7:0];
                    n_out.found_priority = r_best_prio;
                    n_out.status         = r_res_status;
                    n_out.occupancy      = x_occ[5:0];
                    n_out_vld            = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rd_vld = w_issue;
    assign n_rd_idx = r_addr;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ceiling <= 8'hFF;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) r_ceiling <= i_cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_best_id    <= n_best_id;
        r_best_prio  <= n_best_prio;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_issue) r_rd_data <= mem[w_raddr];
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/thread_ready_queue_core.sv =====
// Top level of the thread ready queue.
//
// Input channel: i_in_valid / o_in_stall carry one operation beat (enqueue,
// dequeue, delete, find waiter, select highest). Output channel: o_out_valid /
// i_out_stall carry exactly one result beat per operation, in order.
// i_cfg_we / i_cfg_wdata write the priority ceiling; write it only when idle.
// A two-beat command queue sits between the front decoder and the back
// sequencer, so input beats are taken while a result waits on the output.
// Operations run one at a time. Enqueue and unused codes go from dispatch
// straight to the result; dequeue, delete, find and select scan every held
// entry through the single read port of the store, and dequeue and delete
// with a hit then move the later entries up one place.
// Reset (synchronous, active low) empties the queue, restores a ceiling of
// 255 and drops any pending result; entry contents are not cleared.
// While the receiver stalls, the result beat holds and the sequencer waits,
// and the input stalls once the command queue is full.
module thread_ready_queue_core import trq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    // Decode and buffer incoming beats
    trq_front #(.ID_BITS(ID_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Carry out operations on the entry store
    trq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== rtl/trq_checker.sv =====
// Port-level checker for the ready queue and its bind to the top level.
`include "assert_macros.svh"

module trq_checker import trq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_beat o_out_data,
    input logic      i_out_stall
);

    localparam int         OW    = ($clog2(QUEUE_DEPTH + 1) > 6) ? $clog2(QUEUE_DEPTH + 1) : 6;
    localparam logic [OW-1:0] FULLX = OW'(QUEUE_DEPTH);

    // A stalled result beat stays offered
    `AST_NEXT(a_hold, i_clk, o_out_valid && i_out_stall, o_out_valid, i_rst_n)
    // Reset drops any pending result
    `AST_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !o_out_valid)
    // Status never carries the unused code
    `AST_IMPLIES(a_status, i_clk, i_rst_n, o_out_valid, o_out_data.status != 2'd3)
    // Full is only reported with a full queue and an empty entry
    `AST_IMPLIES(a_full, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_FULL, o_out_data.occupancy == FULLX[5:0] && o_out_data.found_id == 8'd0 && o_out_data.found_priority == 8'd0)

endmodule

bind thread_ready_queue_core trq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_trq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== tb/sv/tb_thread_ready_queue_core.sv =====
// Testbench for the thread ready queue core: directed and random operations checked against a predictor.
`timescale 1ns / 100ps

module tb_thread_ready_queue_core;
    import trq_pkg::*;

    localparam int DEPTH     = 32;
    localparam int LIMIT_CYC = 600000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_beat  i_in_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;

    // predictor state
    logic [7:0] q_ids [DEPTH];
    logic [7:0] q_prio [DEPTH];
    logic [7:0] q_waits [DEPTH];
    int         q_count = 0;
    logic [7:0] ceiling = 8'd255;

    t_out_beat  pending_results [$];
    int         mismatches = 0;
    int         n_items = 0;
    int         n_results = 0;
    int         cycles = 0;
    int         stall_left = 0;
    bit         calm = 1'b0;

    thread_ready_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // give up after a generous number of cycles
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("FAIL thread_ready_queue_core");
            $finish;
        end
    end

    // drop entry at pos and close the gap
    function automatic void queue_remove(input int pos);
        for (int k = pos; k + 1 < q_count; k++) begin
            q_ids[k]   = q_ids[k + 1];
            q_prio[k]  = q_prio[k + 1];
            q_waits[k] = q_waits[k + 1];
        end
        q_count--;
    endfunction

    // work out the result of one operation and advance the queue
    function automatic t_out_beat queue_apply(input t_in_beat b);
        t_out_beat r;
        int        pos;
        bit        hit;
        r = '0;
        r.status = ST_EMPTY;
        hit = 1'b0;
        pos = 0;
        case (b.func)
            FN_ENQ: begin
                if (q_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    q_ids[q_count] = b.thread_id;
                    q_prio[q_count] = b.priority_req;
                    q_waits[q_count] = b.waits_for;
                    q_count++;
                    r.status = ST_OK;
                end
            end
            FN_DEQ: begin
                if (q_count > 0) begin
                    r.found_id = q_ids[0];
                    r.found_priority = q_prio[0];
                    r.status = ST_OK;
                    queue_remove(0);
                end
            end
            FN_DEL: begin
                for (int k = 0; k < q_count && !hit; k++)
                    if (q_ids[k] == b.thread_id) begin
                        hit = 1'b1;
                        pos = k;
                    end
                if (hit) begin
                    r.found_id = q_ids[pos];
                    r.found_priority = q_prio[pos];
                    r.status = ST_OK;
                    queue_remove(pos);
                end
            end
            FN_FIND: begin
                for (int k = 0; k < q_count && !hit; k++)
                    if (q_waits[k] == b.awaited_id) begin
                        hit = 1'b1;
                        pos = k;
                    end
                if (hit) begin
                    r.found_id = q_ids[pos];
                    r.found_priority = q_prio[pos];
                    r.status = ST_OK;
                end
            end
            FN_SEL: begin
                for (int k = 0; k < q_count; k++)
                    if (q_prio[k] <= ceiling && (!hit || q_prio[k] < q_prio[pos])) begin
                        hit = 1'b1;
                        pos = k;
                    end
                if (hit) begin
                    r.found_id = q_ids[pos];
                    r.found_priority = q_prio[pos];
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.occupancy = 6'(q_count);
        return r;
    endfunction

    // send one beat, with an occasional gap before it
    task automatic send_op(input t_in_beat b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(queue_apply(b));
        n_items++;
    endtask

    task automatic send_fields(input logic [2:0] fn, input logic [7:0] tid,
                               input logic [7:0] pr, input logic [7:0] wt,
                               input logic [7:0] aw);
        t_in_beat b;
        b.func = fn;
        b.thread_id = tid;
        b.priority_req = pr;
        b.waits_for = wt;
        b.awaited_id = aw;
        send_op(b);
    endtask

    // wait for all results, then let the sequencer settle before a register write
    task automatic drain_and_write(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ceiling = value;
    endtask

    // random receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (!calm && !i_out_stall && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want id %0d prio %0d st %0d occ %0d, got %0d %0d %0d %0d",
                                 want.found_id, want.found_priority, want.status, want.occupancy,
                                 o_out_data.found_id, o_out_data.found_priority,
                                 o_out_data.status, o_out_data.occupancy);
                end
            end
        end
    end

    task automatic test_directed();
        send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_SEL, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_FIND, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEL, 8'd5, 8'd0, 8'd0, 8'd0);
        send_fields(FN_ENQ, 8'd255, 8'd255, 8'd255, 8'd0);
        send_fields(FN_ENQ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_ENQ, 8'd7, 8'd0, 8'd9, 8'd0);
        send_fields(FN_ENQ, 8'd7, 8'd128, 8'd9, 8'd0);
        send_fields(FN_SEL, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_FIND, 8'd0, 8'd0, 8'd0, 8'd9);
        send_fields(FN_FIND, 8'd0, 8'd0, 8'd0, 8'd1);
        send_fields(FN_DEL, 8'd7, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEL, 8'd77, 8'd0, 8'd0, 8'd0);
        send_fields(3'd5, 8'd1, 8'd1, 8'd1, 8'd1);
        send_fields(3'd6, 8'd2, 8'd2, 8'd2, 8'd2);
        send_fields(3'd7, 8'd3, 8'd3, 8'd3, 8'd3);
        send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // fill to full, overflow, select under a low ceiling, then delete and drain
    task automatic test_full_queue();
        for (int k = 0; k < DEPTH + 2; k++)
            send_fields(FN_ENQ, 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
        drain_and_write(8'd0);
        send_fields(FN_SEL, 8'd0, 8'd0, 8'd0, 8'd0);
        send_fields(FN_DEL, q_ids[DEPTH - 1], 8'd0, 8'd0, 8'd0);
        while (q_count > 0) send_fields(FN_DEQ, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // random operations over a small id range so that hits are common
    task automatic test_random(input int count, input logic [7:0] ceil_val);
        logic [2:0] fn;
        logic [7:0] idmax;
        drain_and_write(ceil_val);
        for (int n = 0; n < count; n++) begin
            idmax = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'd15;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: fn = FN_ENQ;
                7, 8, 9: fn = FN_DEQ;
                10, 11, 12: fn = FN_DEL;
                13, 14, 15: fn = FN_FIND;
                16, 17, 18: fn = FN_SEL;
                default: fn = 3'($urandom_range(5, 7));
            endcase
            send_fields(fn, 8'($urandom_range(0, idmax)), 8'($urandom),
                        8'($urandom_range(0, idmax)), 8'($urandom_range(0, idmax)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_queue();
        test_random(300, 8'd255);
        test_random(300, 8'd100);
        test_random(300, 8'd0);
        calm = 1'b1;
        test_random(300, 8'd200);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("covered %0d operations and %0d result beats, ceilings 255/100/0/200",
                 n_items, n_results);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS thread_ready_queue_core");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL thread_ready_queue_core");
        end
        $finish;
    end
endmodule
